// ----- rtl/gpio_port_with_edge_event_channels_assert.svh -----
// Assertion macros used by the GPIO port RTL.
`ifndef GPIO_PORT_WITH_EDGE_EVENT_CHANNELS_ASSERT_SVH
`define GPIO_PORT_WITH_EDGE_EVENT_CHANNELS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GPEV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gpio port: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GPEV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gpio port: next-cycle check failed");

`endif

// ----- rtl/gpio_ev_pkg.sv -----
// Package of the GPIO port: item codes, register map and field masks.
`timescale 1ns / 1ps

package gpio_ev_pkg;

    localparam int DATA_W = 32;
    localparam int OFF_W  = 12;

    // Item kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_READ  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_TICK  = 2'd2;

    // Register regions
    typedef logic region_t;
    localparam region_t REGION_PORT  = 1'b0;
    localparam region_t REGION_EVENT = 1'b1;

    // Port region map
    localparam logic [OFF_W-1:0] CNF_BASE = 12'h700;
    localparam logic [OFF_W-1:0] OUT_SET  = 12'h508;
    localparam logic [OFF_W-1:0] OUT_CLR  = 12'h50c;
    localparam logic [OFF_W-1:0] IN_REG   = 12'h510;

    // Event region map
    localparam logic [OFF_W-1:0] EV_BASE  = 12'h100;
    localparam logic [OFF_W-1:0] CH_BASE  = 12'h510;
    localparam logic [OFF_W-1:0] EN_SET   = 12'h304;
    localparam logic [OFF_W-1:0] EN_CLR   = 12'h308;

    // Pin configuration: bit0 direction, bit1 input disconnect, 3:2 pull, 10:8 drive
    localparam int PIN_CFG_W = 11;
    typedef logic [PIN_CFG_W-1:0] pin_cfg_t;
    localparam pin_cfg_t CNF_MASK  = 11'h70f;
    localparam pin_cfg_t CNF_RESET = 11'h002;
    localparam int CNF_DIR_BIT  = 0;
    localparam int CNF_DISC_BIT = 1;

    // Channel configuration: 1:0 mode, 12:8 pin, 16 rising, 17 falling
    localparam int CH_CFG_W = 18;
    typedef logic [CH_CFG_W-1:0] ch_cfg_t;
    localparam ch_cfg_t CH_MASK = 18'h31f03;
    localparam logic [1:0] MODE_EVENT = 2'd1;
    localparam int POL_RISE_BIT = 16;
    localparam int POL_FALL_BIT = 17;

endpackage

// ----- rtl/gpio_port_with_edge_event_channels.sv -----
// Top level of the GPIO port with edge-event channels.
`timescale 1ns / 1ps

// GPIO port of PIN_COUNT pins and CHANNEL_COUNT edge-event channels. Each input
// item is a bus read, a bus write or a tick that samples the pin levels; each
// one produces exactly one result item carrying the read data, the output latch,
// the pin directions and the interrupt line as they stand after the item. The
// decode and state update is one level of logic between the input handshake and
// a result register, so an item is taken every cycle unless stalled. s_tready
// drops only while the result register holds an item that the sink has not
// taken yet. Edges are found between consecutive ticks.

`include "gpio_port_with_edge_event_channels_assert.svh"

module gpio_port_with_edge_event_channels
    import gpio_ev_pkg::*;
#(
    parameter int PIN_COUNT     = 32,
    parameter int CHANNEL_COUNT = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // offset[11:0], write_data[43:12], pin_levels[75:44], zeros
    input  logic [2:0]   s_tuser,   // kind[1:0], region[2]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // read_data[31:0], pin_drive[63:32],
                                    // pin_is_output[95:64], irq[96], zeros
);

    localparam int PIN_IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int CH_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CNF_END_I = int'(CNF_BASE) + 4 * PIN_COUNT;
    localparam int EV_END_I  = int'(EV_BASE) + 4 * CHANNEL_COUNT;
    localparam int CH_END_I  = int'(CH_BASE) + 4 * CHANNEL_COUNT;
    localparam logic [OFF_W:0] CNF_END = (OFF_W+1)'(CNF_END_I);
    localparam logic [OFF_W:0] EV_END  = (OFF_W+1)'(EV_END_I);
    localparam logic [OFF_W:0] CH_END  = (OFF_W+1)'(CH_END_I);

    // Input fields
    kind_t             in_kind;
    region_t           in_region;
    logic [OFF_W-1:0]  in_off;
    logic [DATA_W-1:0] in_wdata;
    logic [DATA_W-1:0] in_levels;
    logic              in_accept;

    assign in_kind   = s_tuser[1:0];
    assign in_region = s_tuser[2];
    assign in_off    = s_tdata[11:0];
    assign in_wdata  = s_tdata[43:12];
    assign in_levels = s_tdata[75:44];
    assign in_accept = s_tvalid && s_tready;

    // State
    logic [PIN_COUNT-1:0]     latch_reg, latch_next;
    pin_cfg_t                 pin_cfg_reg [PIN_COUNT];
    pin_cfg_t                 pin_cfg_next [PIN_COUNT];
    logic [PIN_COUNT-1:0]     sampled_reg, sampled_next;
    ch_cfg_t                  ch_cfg_reg [CHANNEL_COUNT];
    ch_cfg_t                  ch_cfg_next [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] flags_reg, flags_next;
    logic [CHANNEL_COUNT-1:0] en_reg, en_next;

    // Result register
    logic               m_valid_reg;
    logic [103:0]       m_data_reg, m_data_next;

    // Address decode
    logic                 aligned;
    logic                 is_port, is_event;
    logic [OFF_W:0]       off_x;
    logic [OFF_W-1:0]     cnf_rel, ev_rel, ch_rel;
    logic [PIN_IDX_W-1:0] cnf_idx;
    logic [CH_IDX_W-1:0]  ev_idx, ch_idx;
    logic                 hit_cnf, hit_out_set, hit_out_clr, hit_in;
    logic                 hit_ev, hit_ch, hit_en_set, hit_en_clr;

    assign aligned  = (in_off[1:0] == 2'b00);
    assign is_port  = aligned && (in_region == REGION_PORT);
    assign is_event = aligned && (in_region == REGION_EVENT);
    assign off_x    = {1'b0, in_off};
    assign cnf_rel  = in_off - CNF_BASE;
    assign ev_rel   = in_off - EV_BASE;
    assign ch_rel   = in_off - CH_BASE;
    assign cnf_idx  = cnf_rel[PIN_IDX_W+1:2];
    assign ev_idx   = ev_rel[CH_IDX_W+1:2];
    assign ch_idx   = ch_rel[CH_IDX_W+1:2];

    assign hit_cnf     = is_port && (in_off >= CNF_BASE) && (off_x < CNF_END);
    assign hit_out_set = is_port && (in_off == OUT_SET);
    assign hit_out_clr = is_port && (in_off == OUT_CLR);
    assign hit_in      = is_port && (in_off == IN_REG);
    assign hit_ev      = is_event && (in_off >= EV_BASE) && (off_x < EV_END);
    assign hit_ch      = is_event && (in_off >= CH_BASE) && (off_x < CH_END);
    assign hit_en_set  = is_event && (in_off == EN_SET);
    assign hit_en_clr  = is_event && (in_off == EN_CLR);

    // Levels seen by software: disconnected pins read 0
    logic [PIN_COUNT-1:0] visible;
    always_comb begin
        for (int n = 0; n < PIN_COUNT; n++) begin
            visible[n] = sampled_reg[n] & ~pin_cfg_reg[n][CNF_DISC_BIT];
        end
    end

    // Read mux
    logic [DATA_W-1:0] rd_data;
    always_comb begin
        rd_data = '0;
        if (hit_cnf) begin
            rd_data = DATA_W'(pin_cfg_reg[cnf_idx]);
        end else if (hit_out_set || hit_out_clr) begin
            rd_data = DATA_W'(latch_reg);
        end else if (hit_in) begin
            rd_data = DATA_W'(visible);
        end else if (hit_ev) begin
            rd_data = DATA_W'(flags_reg[ev_idx]);
        end else if (hit_ch) begin
            rd_data = DATA_W'(ch_cfg_reg[ch_idx]);
        end else if (hit_en_set || hit_en_clr) begin
            rd_data = DATA_W'(en_reg);
        end
    end

    // Edge detection on the tick levels
    logic [PIN_COUNT-1:0]     now_lv;
    logic [DATA_W-1:0]        rise_w, fall_w;
    logic [CHANNEL_COUNT-1:0] ch_hit;
    always_comb begin
        now_lv = in_levels[PIN_COUNT-1:0];
        rise_w = '0;
        fall_w = '0;
        rise_w[PIN_COUNT-1:0] = now_lv & ~sampled_reg;
        fall_w[PIN_COUNT-1:0] = sampled_reg & ~now_lv;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            ch_hit[i] = (ch_cfg_reg[i][1:0] == MODE_EVENT)
                     && ({1'b0, ch_cfg_reg[i][12:8]} < 6'(PIN_COUNT))
                     && ((ch_cfg_reg[i][POL_RISE_BIT] && rise_w[ch_cfg_reg[i][12:8]])
                      || (ch_cfg_reg[i][POL_FALL_BIT] && fall_w[ch_cfg_reg[i][12:8]]));
        end
    end

    // Next state
    always_comb begin
        latch_next   = latch_reg;
        pin_cfg_next = pin_cfg_reg;
        sampled_next = sampled_reg;
        ch_cfg_next  = ch_cfg_reg;
        flags_next   = flags_reg;
        en_next      = en_reg;
        if (in_accept) begin
            case (in_kind)
                KIND_WRITE: begin
                    if (hit_cnf) begin
                        pin_cfg_next[cnf_idx] = in_wdata[PIN_CFG_W-1:0] & CNF_MASK;
                    end
                    if (hit_out_set) begin
                        latch_next = latch_reg | in_wdata[PIN_COUNT-1:0];
                    end
                    if (hit_out_clr) begin
                        latch_next = latch_reg & ~in_wdata[PIN_COUNT-1:0];
                    end
                    if (hit_ev && (in_wdata == '0)) begin
                        flags_next[ev_idx] = 1'b0;
                    end
                    if (hit_ch) begin
                        ch_cfg_next[ch_idx] = in_wdata[CH_CFG_W-1:0] & CH_MASK;
                    end
                    if (hit_en_set) begin
                        en_next = en_reg | in_wdata[CHANNEL_COUNT-1:0];
                    end
                    if (hit_en_clr) begin
                        en_next = en_reg & ~in_wdata[CHANNEL_COUNT-1:0];
                    end
                end
                KIND_TICK: begin
                    flags_next   = flags_reg | ch_hit;
                    sampled_next = now_lv;
                end
                default: begin
                end
            endcase
        end
    end

    // Result: read data plus the port outputs after this item
    logic [PIN_COUNT-1:0] dir_next;
    always_comb begin
        for (int n = 0; n < PIN_COUNT; n++) begin
            dir_next[n] = pin_cfg_next[n][CNF_DIR_BIT];
        end
        m_data_next = '0;
        m_data_next[31:0]  = (in_kind == KIND_READ) ? rd_data : '0;
        m_data_next[63:32] = DATA_W'(latch_next);
        m_data_next[95:64] = DATA_W'(dir_next);
        m_data_next[96]    = |(flags_next & en_next);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg   <= '0;
            sampled_reg <= '0;
            flags_reg   <= '0;
            en_reg      <= '0;
            for (int n = 0; n < PIN_COUNT; n++) begin
                pin_cfg_reg[n] <= CNF_RESET;
            end
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                ch_cfg_reg[i] <= '0;
            end
        end else begin
            latch_reg   <= latch_next;
            pin_cfg_reg <= pin_cfg_next;
            sampled_reg <= sampled_next;
            ch_cfg_reg  <= ch_cfg_next;
            flags_reg   <= flags_next;
            en_reg      <= en_next;
        end
    end

    // Result register and handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `GPEV_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid_reg && !m_tready, !s_tready)
    `GPEV_ASSERT_NEXT(a_irq_matches_state, aclk, aresetn, in_accept, m_data_reg[96] == |(flags_reg & en_reg))
    `GPEV_ASSERT_NEXT(a_flags_rise_on_tick, aclk, aresetn, !(in_accept && (in_kind == KIND_TICK)), (flags_reg & ~$past(flags_reg)) == '0)
    `GPEV_ASSERT_NEXT(a_read_keeps_latch, aclk, aresetn, in_accept && (in_kind == KIND_READ), $stable(latch_reg) && $stable(flags_reg))

endmodule

// ----- dv/tb_top.sv -----
// Testbench of the GPIO port: directed and random bus and tick items checked against a shadow model.
`timescale 1ns / 1ps

module tb_top
    import gpio_ev_pkg::*;
();

    localparam int PIN_COUNT     = 32;
    localparam int CHANNEL_COUNT = 8;
    localparam int PIN_IDX_W     = $clog2(PIN_COUNT);
    localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
    localparam int RANDOM_ITEMS  = 600;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam logic [31:0] PIN_MASK =
        (PIN_COUNT >= 32) ? 32'hffff_ffff : ((32'd1 << PIN_COUNT) - 32'd1);

    // One result item as it travels in m_tdata, read_data in the lowest bits
    typedef struct packed {
        logic        irq;
        logic [31:0] pin_is_output;
        logic [31:0] pin_drive;
        logic [31:0] read_data;
    } gpio_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata  = '0;    // offset[11:0], write_data[43:12], pin_levels[75:44], zeros
    logic [2:0]   s_tuser  = '0;    // kind[1:0], region[2]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;          // read_data[31:0], pin_drive[63:32],
                                    // pin_is_output[95:64], irq[96], zeros

    // Shadow copy of the port state
    logic [31:0]              shadow_latch;
    pin_cfg_t                 shadow_pin_cfg [PIN_COUNT];
    logic [31:0]              shadow_levels;
    ch_cfg_t                  shadow_ch_cfg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] shadow_flags;
    logic [CHANNEL_COUNT-1:0] shadow_irq_en;

    gpio_result_t pending_results[$];
    int           err_count   = 0;
    int           cycle_count = 0;
    int           stall_left  = 0;
    bit           idle_on     = 1'b1;

    gpio_port_with_edge_event_channels #(
        .PIN_COUNT     (PIN_COUNT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        int n;
        shadow_latch  = '0;
        shadow_levels = '0;
        shadow_flags  = '0;
        shadow_irq_en = '0;
        for (n = 0; n < PIN_COUNT; n++)
            shadow_pin_cfg[n] = CNF_RESET;
        for (n = 0; n < CHANNEL_COUNT; n++)
            shadow_ch_cfg[n] = '0;
    endfunction

    function automatic logic [31:0] shadow_read(region_t region, logic [OFF_W-1:0] off);
        logic [31:0] visible;
        int          n;
        visible = '0;
        if (off[1:0] != 2'b00)
            return '0;
        if (region == REGION_PORT) begin
            if (off >= CNF_BASE && off < CNF_BASE + 4 * PIN_COUNT)
                return 32'(shadow_pin_cfg[PIN_IDX_W'((off - CNF_BASE) >> 2)]);
            if (off == OUT_SET || off == OUT_CLR)
                return shadow_latch;
            if (off == IN_REG) begin
                // disconnected inputs read 0
                for (n = 0; n < PIN_COUNT; n++)
                    if (!shadow_pin_cfg[n][CNF_DISC_BIT])
                        visible[n] = shadow_levels[n];
                return visible;
            end
            return '0;
        end
        if (off >= EV_BASE && off < EV_BASE + 4 * CHANNEL_COUNT)
            return 32'(shadow_flags[CH_IDX_W'((off - EV_BASE) >> 2)]);
        if (off >= CH_BASE && off < CH_BASE + 4 * CHANNEL_COUNT)
            return 32'(shadow_ch_cfg[CH_IDX_W'((off - CH_BASE) >> 2)]);
        if (off == EN_SET || off == EN_CLR)
            return 32'(shadow_irq_en);
        return '0;
    endfunction

    function automatic void shadow_write(region_t region, logic [OFF_W-1:0] off,
                                         logic [31:0] d);
        if (off[1:0] != 2'b00)
            return;
        if (region == REGION_PORT) begin
            if (off >= CNF_BASE && off < CNF_BASE + 4 * PIN_COUNT)
                shadow_pin_cfg[PIN_IDX_W'((off - CNF_BASE) >> 2)] = pin_cfg_t'(d) & CNF_MASK;
            else if (off == OUT_SET)
                shadow_latch = (shadow_latch | d) & PIN_MASK;
            else if (off == OUT_CLR)
                shadow_latch = shadow_latch & ~d;
            return;
        end
        if (off >= EV_BASE && off < EV_BASE + 4 * CHANNEL_COUNT) begin
            // only a zero write clears a flag
            if (d == '0)
                shadow_flags[CH_IDX_W'((off - EV_BASE) >> 2)] = 1'b0;
        end else if (off >= CH_BASE && off < CH_BASE + 4 * CHANNEL_COUNT) begin
            shadow_ch_cfg[CH_IDX_W'((off - CH_BASE) >> 2)] = ch_cfg_t'(d) & CH_MASK;
        end else if (off == EN_SET) begin
            shadow_irq_en = shadow_irq_en | d[CHANNEL_COUNT-1:0];
        end else if (off == EN_CLR) begin
            shadow_irq_en = shadow_irq_en & ~d[CHANNEL_COUNT-1:0];
        end
    endfunction

    // Edge detection between the previous and the current sample
    function automatic void shadow_tick(logic [31:0] levels);
        logic [31:0] cur_levels, rise, fall;
        ch_cfg_t     cfg;
        logic [4:0]  pin;
        int          i;
        cur_levels = levels & PIN_MASK;
        rise       = cur_levels & ~shadow_levels;
        fall       = shadow_levels & ~cur_levels;
        for (i = 0; i < CHANNEL_COUNT; i++) begin
            cfg = shadow_ch_cfg[i];
            pin = cfg[12:8];
            if (cfg[1:0] == MODE_EVENT && int'(pin) < PIN_COUNT) begin
                if ((cfg[POL_RISE_BIT] && rise[pin]) || (cfg[POL_FALL_BIT] && fall[pin]))
                    shadow_flags[i] = 1'b1;
            end
        end
        shadow_levels = cur_levels;
    endfunction

    function automatic gpio_result_t predict_result(kind_t kind, region_t region,
                                                    logic [OFF_W-1:0] off,
                                                    logic [31:0] wdata,
                                                    logic [31:0] levels);
        gpio_result_t res;
        int           n;
        res = '0;
        case (kind)
            KIND_READ:  res.read_data = shadow_read(region, off);
            KIND_WRITE: shadow_write(region, off, wdata);
            KIND_TICK:  shadow_tick(levels);
            default:    ;
        endcase
        res.pin_drive = shadow_latch;
        for (n = 0; n < PIN_COUNT; n++)
            res.pin_is_output[n] = shadow_pin_cfg[n][CNF_DIR_BIT];
        res.irq = |(shadow_flags & shadow_irq_en);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------

    task automatic send_item(kind_t kind, region_t region, logic [OFF_W-1:0] off,
                             logic [31:0] wdata, logic [31:0] levels);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {region, kind};
        s_tdata  <= {4'b0, levels, wdata, off};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_result(kind, region, off, wdata, levels));
    endtask

    task automatic reg_write(region_t region, logic [OFF_W-1:0] off, logic [31:0] d);
        send_item(KIND_WRITE, region, off, d, $urandom());
    endtask

    task automatic reg_read(region_t region, logic [OFF_W-1:0] off);
        send_item(KIND_READ, region, off, $urandom(), $urandom());
    endtask

    task automatic pin_tick(logic [31:0] levels);
        send_item(KIND_TICK, region_t'($urandom_range(0, 1)), OFF_W'($urandom()),
                  $urandom(), levels);
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    function automatic logic [31:0] chan_word(logic [1:0] mode, logic [4:0] pin,
                                              bit on_rise, bit on_fall);
        logic [31:0] w;
        w = 32'(mode) | (32'(pin) << 8);
        w[POL_RISE_BIT] = on_rise;
        w[POL_FALL_BIT] = on_fall;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        gpio_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[96:0];
            if (pending_results.size() == 0) begin
                err_count++;
                $error("result item with nothing expected: %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    err_count++;
                    $error("read_data mismatch: expected %h, actual %h",
                           want.read_data, got.read_data);
                end
                if (got.pin_drive !== want.pin_drive) begin
                    err_count++;
                    $error("pin_drive mismatch: expected %h, actual %h",
                           want.pin_drive, got.pin_drive);
                end
                if (got.pin_is_output !== want.pin_is_output) begin
                    err_count++;
                    $error("pin_is_output mismatch: expected %h, actual %h",
                           want.pin_is_output, got.pin_is_output);
                end
                if (got.irq !== want.irq) begin
                    err_count++;
                    $error("irq mismatch: expected %b, actual %b", want.irq, got.irq);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_state();
        reg_read(REGION_PORT, IN_REG);
        reg_read(REGION_PORT, CNF_BASE);
        reg_read(REGION_EVENT, EN_SET);
    endtask

    task automatic test_output_latch();
        reg_write(REGION_PORT, OUT_SET, 32'hffff_ffff);
        reg_write(REGION_PORT, OUT_CLR, 32'h0000_ffff);
        reg_read(REGION_PORT, OUT_CLR);
        reg_write(REGION_PORT, OUT_CLR, 32'hffff_ffff);
    endtask

    // Direction and input disconnect on the first and last pin
    task automatic test_pin_config();
        reg_write(REGION_PORT, CNF_BASE, 32'hffff_ffff);
        reg_write(REGION_PORT, OFF_W'(CNF_BASE + 4 * (PIN_COUNT - 1)), 32'h0000_0001);
        pin_tick(32'hffff_ffff);
        reg_read(REGION_PORT, IN_REG);
        reg_read(REGION_PORT, CNF_BASE);
    endtask

    // Rising, falling and either edge; a non-event mode and empty polarity stay quiet
    task automatic test_edge_events();
        reg_write(REGION_EVENT, CH_BASE, chan_word(MODE_EVENT, 5'd0, 1'b1, 1'b0));
        reg_write(REGION_EVENT, OFF_W'(CH_BASE + 4 * 5), chan_word(MODE_EVENT, 5'd0, 1'b1, 1'b1));
        reg_write(REGION_EVENT, OFF_W'(CH_BASE + 4 * 7), chan_word(MODE_EVENT, 5'd31, 1'b0, 1'b1));
        reg_write(REGION_EVENT, OFF_W'(CH_BASE + 4 * 2), chan_word(MODE_EVENT, 5'd31, 1'b0, 1'b0));
        reg_write(REGION_EVENT, OFF_W'(CH_BASE + 4 * 3), 32'hffff_ffff);
        reg_write(REGION_EVENT, EN_SET, 32'hffff_ffff);
        pin_tick(32'h0000_0000);
        pin_tick(32'h0000_0001);
        reg_write(REGION_EVENT, OFF_W'(EV_BASE + 4 * 7), 32'h0000_0005);
        reg_write(REGION_EVENT, OFF_W'(EV_BASE + 4 * 7), 32'h0000_0000);
        reg_read(REGION_EVENT, EV_BASE);
        reg_write(REGION_EVENT, EN_CLR, 32'h0000_0021);
    endtask

    // Unaligned, read-only, out-of-range and unused-kind accesses
    task automatic test_odd_accesses();
        reg_read(REGION_PORT, OUT_SET + 12'd1);
        reg_write(REGION_PORT, IN_REG, 32'hffff_ffff);
        send_item(KIND_UNUSED, REGION_PORT, OUT_SET, 32'hffff_ffff, 32'hffff_ffff);
        reg_write(REGION_EVENT, OFF_W'(CH_BASE + 4 * CHANNEL_COUNT), 32'hffff_ffff);
        reg_read(REGION_EVENT, 12'hfff);
    endtask

    function automatic logic [OFF_W-1:0] pick_offset(region_t region);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return OFF_W'($urandom());      // noise: mostly unmapped or unaligned
        if (region == REGION_PORT) begin
            case (sel)
                1, 2:    return OUT_SET;
                3, 4:    return OUT_CLR;
                5:       return IN_REG;
                default: return OFF_W'(CNF_BASE + 4 * $urandom_range(0, PIN_COUNT + 3));
            endcase
        end
        case (sel)
            1, 2:    return OFF_W'(EV_BASE + 4 * $urandom_range(0, CHANNEL_COUNT + 1));
            3:       return EN_SET;
            4:       return EN_CLR;
            default: return OFF_W'(CH_BASE + 4 * $urandom_range(0, CHANNEL_COUNT + 1));
        endcase
    endfunction

    task automatic send_random_item();
        kind_t            kind;
        region_t          region;
        logic [OFF_W-1:0] off;
        logic [31:0]      wdata, levels;
        logic [1:0]       mode;
        int               pick;
        pick   = $urandom_range(0, 99);
        kind   = (pick < 35) ? KIND_READ : (pick < 70) ? KIND_WRITE :
                 (pick < 97) ? KIND_TICK : KIND_UNUSED;
        region = region_t'($urandom_range(0, 1));
        off    = pick_offset(region);
        wdata  = $urandom();

        // well-formed channel settings and flag clears most of the time
        if (region == REGION_EVENT && off >= CH_BASE && off < CH_BASE + 4 * CHANNEL_COUNT) begin
            mode  = ($urandom_range(0, 9) < 7) ? MODE_EVENT : 2'($urandom_range(0, 3));
            wdata = chan_word(mode, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
                wdata = wdata | $urandom();
        end else if (region == REGION_EVENT && off >= EV_BASE &&
                     off < EV_BASE + 4 * CHANNEL_COUNT) begin
            if ($urandom_range(0, 3) != 0)
                wdata = '0;
        end else if (off == OUT_CLR || off == EN_CLR) begin
            wdata = $urandom() & $urandom();
        end

        // ticks either jump anywhere or flip a single pin
        if ($urandom_range(0, 1) == 0)
            levels = $urandom();
        else
            levels = shadow_levels ^ (32'd1 << $urandom_range(0, PIN_COUNT - 1));

        send_item(kind, region, off, wdata, levels);
    endtask

    task automatic test_random_traffic(int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i == count / 3)
                wait_drained();
            if (i == count - count / 6)
                idle_on = 1'b0;
            send_random_item();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        reset_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_output_latch();
        test_pin_config();
        test_edge_events();
        test_odd_accesses();
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
